FILE: rtl/core/drap_pkg.sv
// ----------------------------------------------------------------------------
// Dual-range average position: shared package
// Window geometry, derived widths, register codes and the structs that pass
// between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package drap_pkg;

   // Moving-average window depth and the widths that follow from it.
   localparam int WINDOW  = 30;
   localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W   = $clog2(WINDOW + 1);

   // Sample widths. The far sample is at most 8191 / 10 + 255.
   localparam int NEAR_W  = 8;
   localparam int FAR_MM_W = 13;
   localparam int FAR_W   = 11;
   localparam int FAR_MAX = 1074;
   localparam int SUM_W   = $clog2(WINDOW * FAR_MAX + 1);

   // Averages carry eight fraction bits.
   localparam int FRAC_W  = 8;
   localparam int DIV_W   = SUM_W + FRAC_W;
   localparam int ITER_W  = $clog2(DIV_W);
   localparam int PROD_W  = SUM_W + CNT_W;

   // Result field widths.
   localparam int POS_W   = 20;
   localparam int NAVG_W  = 16;
   localparam int FAVG_W  = 19;

   // Millimetres to centimetres: multiply by 6554 / 65536, exact for 13 bits.
   localparam int MM_RECIP       = 6554;
   localparam int MM_RECIP_SHIFT = 16;
   localparam int MM_PROD_W      = 26;

   // Queue between the front end and the back end.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SHIFT_EXPONENT    = 3'd0,
      CSR_NEAR_OFFSET       = 3'd1,
      CSR_FAR_OFFSET        = 3'd2,
      CSR_TRACK_LENGTH      = 3'd3,
      CSR_FALLBACK_DISTANCE = 3'd4
   } csr_index_type;

   localparam logic [2:0] RST_SHIFT_EXPONENT    = 3'd0;
   localparam logic [7:0] RST_NEAR_OFFSET       = 8'd3;
   localparam logic [7:0] RST_FAR_OFFSET        = 8'd0;
   localparam logic [7:0] RST_TRACK_LENGTH      = 8'd50;
   localparam logic [7:0] RST_FALLBACK_DISTANCE = 8'd50;

   typedef struct packed {
      logic [2:0] shift_exponent;
      logic [7:0] near_offset;
      logic [7:0] far_offset;
      logic [7:0] track_length;
      logic [7:0] fallback_distance;
   } cfg_type;

   // One classified transaction waiting for the back end.
   typedef struct packed {
      logic [NEAR_W-1:0] near_sample;
      logic [FAR_W-1:0]  far_sample;
      logic              far_add;
   } entry_type;

   // Running totals of one window.
   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] count;
   } win_status_type;

endpackage

FILE: rtl/core/drap_if.sv
// ----------------------------------------------------------------------------
// Dual-range average position: channel interfaces
// Request channel with the raw sensor readings and response channel with the
// computed position, each with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface drap_req_if;
   logic                          valid;
   logic                          ready;
   logic [7:0]                    near_high;
   logic [7:0]                    near_low;
   logic                          near_ok;
   logic [drap_pkg::FAR_MM_W-1:0] far_mm;
   logic                          far_ready;

   modport source (output valid, near_high, near_low, near_ok, far_mm, far_ready,
                   input ready);
   modport sink   (input valid, near_high, near_low, near_ok, far_mm, far_ready,
                   output ready);
endinterface

interface drap_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [drap_pkg::POS_W-1:0]  position;
   logic [drap_pkg::NAVG_W-1:0]        near_average;
   logic [drap_pkg::FAVG_W-1:0]        far_average;
   logic                               far_chosen;

   modport source (output valid, position, near_average, far_average, far_chosen,
                   input ready);
   modport sink   (input valid, position, near_average, far_average, far_chosen,
                   output ready);
endinterface

FILE: rtl/core/drap_front.sv
// ----------------------------------------------------------------------------
// Dual-range average position: front end
// Accepts request transactions and turns the raw readings into one near
// sample and, when present, one far sample in centimetres.
// ----------------------------------------------------------------------------
module drap_front (
   drap_req_if.sink              req_chan,
   input  drap_pkg::cfg_type     cfg,
   input  logic                  queue_full,
   output logic                  push,
   output drap_pkg::entry_type   entry
);

   logic [8:0]                                 near_raw;
   logic [8:0]                                 near_shifted;
   logic [drap_pkg::MM_PROD_W-1:0]             mm_prod;
   logic [drap_pkg::MM_PROD_W-drap_pkg::MM_RECIP_SHIFT-1:0] far_cm;

   assign req_chan.ready = !queue_full;
   assign push           = req_chan.valid && !queue_full;

   always_comb begin
      near_raw     = {1'b0, req_chan.near_high} + {5'b0, req_chan.near_low[7:4]};
      near_shifted = near_raw >> cfg.shift_exponent;
      mm_prod      = drap_pkg::MM_PROD_W'(req_chan.far_mm)
                   * drap_pkg::MM_PROD_W'(drap_pkg::MM_RECIP);
      far_cm       = mm_prod[drap_pkg::MM_PROD_W-1:drap_pkg::MM_RECIP_SHIFT];

      if (req_chan.near_ok) begin
         entry.near_sample = near_shifted[7:0] + cfg.near_offset;
      end else begin
         entry.near_sample = cfg.fallback_distance;
      end
      entry.far_sample = drap_pkg::FAR_W'(far_cm) + drap_pkg::FAR_W'(cfg.far_offset);
      entry.far_add    = req_chan.far_ready;
   end

endmodule

FILE: rtl/core/drap_queue.sv
// ----------------------------------------------------------------------------
// Dual-range average position: transaction queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module drap_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  drap_pkg::entry_type entry,
   input  logic                pop,
   output drap_pkg::entry_type head,
   output logic                full,
   output logic                empty
);

   drap_pkg::entry_type               slots_ff [drap_pkg::QUEUE_DEPTH];
   logic [drap_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [drap_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [drap_pkg::QCNT_W-1:0]       count_ff, count_in;

   function automatic logic [drap_pkg::QPTR_W-1:0] next_ptr(
      input logic [drap_pkg::QPTR_W-1:0] ptr);
      if (ptr == drap_pkg::QPTR_W'(drap_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   assign full  = (count_ff == drap_pkg::QCNT_W'(drap_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

FILE: rtl/core/drap_window.sv
// ----------------------------------------------------------------------------
// Dual-range average position: moving-average window
// Sample store with running sum, fill count and write slot. Once full, the
// sample being overwritten is taken off the sum.
// ----------------------------------------------------------------------------
module drap_window (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         add,
   input  logic [drap_pkg::FAR_W-1:0]   value,
   output drap_pkg::win_status_type     status
);

   logic [drap_pkg::FAR_W-1:0]  store_ff [drap_pkg::WINDOW];
   logic [drap_pkg::FAR_W-1:0]  oldest_ff;
   logic [drap_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic [drap_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [drap_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic                        full;

   assign full         = (count_ff == drap_pkg::CNT_W'(drap_pkg::WINDOW));
   assign status.sum   = sum_ff;
   assign status.count = count_ff;

   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      if (add) begin
         sum_in = sum_ff - (full ? drap_pkg::SUM_W'(oldest_ff) : '0)
                + drap_pkg::SUM_W'(value);
         if (!full) begin
            count_in = count_ff + 1'b1;
         end
         if (slot_ff == drap_pkg::SLOT_W'(drap_pkg::WINDOW - 1)) begin
            slot_in = '0;
         end else begin
            slot_in = slot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         slot_ff  <= slot_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   // The entry at the current slot is read every cycle, so it is ready well
   // before the next add.
   always_ff @(posedge clock) begin
      if (add) begin
         store_ff[slot_ff] <= value;
      end
      oldest_ff <= store_ff[slot_ff];
   end

endmodule

FILE: rtl/core/drap_divider.sv
// ----------------------------------------------------------------------------
// Dual-range average position: serial divider
// Restoring division, one quotient bit per cycle, of a scaled window sum by
// the window fill count.
// ----------------------------------------------------------------------------
module drap_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [drap_pkg::DIV_W-1:0]  dividend,
   input  logic [drap_pkg::CNT_W-1:0]  divisor,
   output logic                        busy,
   output logic [drap_pkg::DIV_W-1:0]  quotient
);

   logic                        busy_ff, busy_in;
   logic [drap_pkg::ITER_W-1:0] iter_ff, iter_in;
   logic [drap_pkg::DIV_W-1:0]  quo_ff, quo_in;
   logic [drap_pkg::CNT_W-1:0]  rem_ff, rem_in;
   logic [drap_pkg::CNT_W-1:0]  divisor_ff, divisor_in;
   logic [drap_pkg::CNT_W:0]    trial;
   logic                        fits;

   assign busy     = busy_ff;
   assign quotient = quo_ff;

   always_comb begin
      trial      = {rem_ff, quo_ff[drap_pkg::DIV_W-1]};
      fits       = (trial >= {1'b0, divisor_ff});
      busy_in    = busy_ff;
      iter_in    = iter_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         iter_in    = '0;
         quo_in     = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[drap_pkg::DIV_W-2:0], fits};
         rem_in  = fits ? drap_pkg::CNT_W'(trial - {1'b0, divisor_ff})
                        : trial[drap_pkg::CNT_W-1:0];
         iter_in = iter_ff + 1'b1;
         if (iter_ff == drap_pkg::ITER_W'(drap_pkg::DIV_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

endmodule

FILE: rtl/core/drap_back.sv
// ----------------------------------------------------------------------------
// Dual-range average position: back end
// Takes queued transactions, updates both windows, forms both averages with
// serial dividers, picks the position and holds it in the response register.
// ----------------------------------------------------------------------------
module drap_back (
   input  logic                clock,
   input  logic                reset,
   input  drap_pkg::entry_type head,
   input  logic                empty,
   output logic                pop,
   input  logic [7:0]          track_length,
   drap_rsp_if.source          rsp_chan
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_MUL  = 4'b0010,
      S_DIV  = 4'b0100,
      S_OUT  = 4'b1000
   } back_state_type;

   back_state_type                 state_ff, state_in;
   drap_pkg::win_status_type       near_stat, far_stat;
   logic [drap_pkg::PROD_W-1:0]    near_prod_ff, near_prod_in;
   logic [drap_pkg::PROD_W-1:0]    far_prod_ff, far_prod_in;
   logic                           div_start;
   logic                           near_busy, far_busy;
   logic [drap_pkg::DIV_W-1:0]     near_quo, far_quo;
   logic                           load;
   logic                           near_wins;
   logic [drap_pkg::NAVG_W-1:0]    navg;
   logic [drap_pkg::FAVG_W-1:0]    favg;

   logic                           valid_ff, valid_in;
   logic [drap_pkg::POS_W-1:0]     position_ff, position_in;
   logic [drap_pkg::NAVG_W-1:0]    navg_ff, navg_in;
   logic [drap_pkg::FAVG_W-1:0]    favg_ff, favg_in;
   logic                           chosen_ff, chosen_in;

   assign pop = (state_ff == S_IDLE) && !empty;

   drap_window u_near_window (
      .clock  (clock),
      .reset  (reset),
      .add    (pop),
      .value  (drap_pkg::FAR_W'(head.near_sample)),
      .status (near_stat)
   );

   drap_window u_far_window (
      .clock  (clock),
      .reset  (reset),
      .add    (pop && head.far_add),
      .value  (head.far_sample),
      .status (far_stat)
   );

   drap_divider u_near_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({near_stat.sum, drap_pkg::FRAC_W'(0)}),
      .divisor  (near_stat.count),
      .busy     (near_busy),
      .quotient (near_quo)
   );

   drap_divider u_far_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({far_stat.sum, drap_pkg::FRAC_W'(0)}),
      .divisor  (far_stat.count),
      .busy     (far_busy),
      .quotient (far_quo)
   );

   always_comb begin
      navg = (near_stat.count == '0) ? '0 : near_quo[drap_pkg::NAVG_W-1:0];
      favg = (far_stat.count == '0)  ? '0 : far_quo[drap_pkg::FAVG_W-1:0];

      // Compare the exact fractions by cross products.
      if (near_stat.count == '0) begin
         near_wins = (far_stat.count != '0) && (far_stat.sum != '0);
      end else if (far_stat.count == '0) begin
         near_wins = 1'b0;
      end else begin
         near_wins = (near_prod_ff < far_prod_ff);
      end

      state_in     = state_ff;
      near_prod_in = near_prod_ff;
      far_prod_in  = far_prod_ff;
      div_start    = 1'b0;
      load         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (pop) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            near_prod_in = drap_pkg::PROD_W'(near_stat.sum)
                         * drap_pkg::PROD_W'(far_stat.count);
            far_prod_in  = drap_pkg::PROD_W'(far_stat.sum)
                         * drap_pkg::PROD_W'(near_stat.count);
            div_start    = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            if (!near_busy && !far_busy) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            load = !valid_ff || rsp_chan.ready;
            if (load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      valid_in    = valid_ff;
      position_in = position_ff;
      navg_in     = navg_ff;
      favg_in     = favg_ff;
      chosen_in   = chosen_ff;
      if (valid_ff && rsp_chan.ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in  = 1'b1;
         navg_in   = navg;
         favg_in   = favg;
         chosen_in = !near_wins;
         if (near_wins) begin
            position_in = drap_pkg::POS_W'(navg);
         end else begin
            position_in = drap_pkg::POS_W'({track_length, drap_pkg::FRAC_W'(0)})
                        - drap_pkg::POS_W'(favg);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      near_prod_ff <= near_prod_in;
      far_prod_ff  <= far_prod_in;
      position_ff  <= position_in;
      navg_ff      <= navg_in;
      favg_ff      <= favg_in;
      chosen_ff    <= chosen_in;
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.position     = position_ff;
   assign rsp_chan.near_average = navg_ff;
   assign rsp_chan.far_average  = favg_ff;
   assign rsp_chan.far_chosen   = chosen_ff;

   // A near-chosen result carries the near average as its position.
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !chosen_ff) |-> (position_ff == drap_pkg::POS_W'(navg_ff)))
      else $error("near-chosen position differs from near average");

   // Every transaction taken from the queue leaves a non-empty near window.
   assert property (@(posedge clock) disable iff (reset)
      pop |=> (near_stat.count != '0))
      else $error("near window empty after an update");

   // A loaded result is offered on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff)
      else $error("loaded result not offered");

endmodule

FILE: rtl/core/dual_range_average_position_unit.sv
// ----------------------------------------------------------------------------
// Dual-range average position unit
// Ball position from a near and a far distance sensor, each smoothed by its
// own moving-average window.
// ----------------------------------------------------------------------------
// Each request transaction carries one near reading and, when far_ready is
// set, one far reading; each produces exactly one response transaction, in
// order. In the back end a transaction updates the near window, and the far
// window when it carries a far reading, then forms the cross products and
// starts division, runs through the two bit-serial dividers side by side,
// waits for both dividers to finish and loads the response register; the back
// end takes no new transaction until that response is loaded. The front
// end classifies requests and places them in a two-entry queue, so up to two
// further requests are taken while one is being worked on or a response waits
// to be taken. No clearing pass is needed after reset: a window only reads
// back entries it has already written. Configuration registers must be
// written only while the unit is idle.
// ----------------------------------------------------------------------------
module dual_range_average_position_unit (
   input  logic                              clock,
   input  logic                              reset,
   drap_req_if.sink                          req_chan,
   drap_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [drap_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [drap_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   drap_pkg::cfg_type   cfg_ff, cfg_in;
   drap_pkg::entry_type entry;
   drap_pkg::entry_type head;
   logic                push;
   logic                pop;
   logic                queue_full;
   logic                queue_empty;

   // Configuration registers. Writes to an index beyond the list are dropped,
   // and only the low bits that a register holds are kept.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (drap_pkg::csr_index_type'(csr_index))
            drap_pkg::CSR_SHIFT_EXPONENT:    cfg_in.shift_exponent    = csr_wdata[2:0];
            drap_pkg::CSR_NEAR_OFFSET:       cfg_in.near_offset       = csr_wdata;
            drap_pkg::CSR_FAR_OFFSET:        cfg_in.far_offset        = csr_wdata;
            drap_pkg::CSR_TRACK_LENGTH:      cfg_in.track_length      = csr_wdata;
            drap_pkg::CSR_FALLBACK_DISTANCE: cfg_in.fallback_distance = csr_wdata;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.shift_exponent    <= drap_pkg::RST_SHIFT_EXPONENT;
         cfg_ff.near_offset       <= drap_pkg::RST_NEAR_OFFSET;
         cfg_ff.far_offset        <= drap_pkg::RST_FAR_OFFSET;
         cfg_ff.track_length      <= drap_pkg::RST_TRACK_LENGTH;
         cfg_ff.fallback_distance <= drap_pkg::RST_FALLBACK_DISTANCE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: accepts a request and converts both readings to centimetres.
   drap_front u_front (
      .req_chan   (req_chan),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push),
      .entry      (entry)
   );

   // The queue lets the front end keep accepting while the back end divides.
   drap_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .entry (entry),
      .pop   (pop),
      .head  (head),
      .full  (queue_full),
      .empty (queue_empty)
   );

   // Back end: windows, averages, position choice and response register.
   drap_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .empty        (queue_empty),
      .pop          (pop),
      .track_length (cfg_ff.track_length),
      .rsp_chan     (rsp_chan)
   );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dual-range average position unit: self-checking testbench
// Drives near and far sensor readings through the request channel, predicts
// each response with a cycle-free model of both moving-average windows, and
// compares every response field by field, in order, under random idling on
// both channels and several register settings.
// ----------------------------------------------------------------------------
module testbench;

   // Cycles to let pass after the last response before registers are touched
   // or the run is closed: a little more than one back-end pass.
   localparam int SETTLE_CYCLES    = 40;
   // Long receiver hold-off that lets the two-entry queue fill and forces the
   // unit to stall its request channel.
   localparam int LONG_HOLD_CYCLES = 250;
   localparam int RANDOM_PHASES    = 6;
   localparam int ITEMS_PER_PHASE  = 300;
   localparam int REPORT_LIMIT     = 10;
   // Register indexes past the last defined register; writes to them must be
   // dropped by the unit.
   localparam int FIRST_SPARE_INDEX = int'(drap_pkg::CSR_FALLBACK_DISTANCE) + 1;

   // One request transaction as the sensors deliver it.
   typedef struct packed {
      logic [7:0]                    near_high;
      logic [7:0]                    near_low;
      logic                          near_ok;
      logic [drap_pkg::FAR_MM_W-1:0] far_mm;
      logic                          far_ready;
   } sensor_reading_type;

   // One response transaction.
   typedef struct packed {
      logic [drap_pkg::POS_W-1:0]  position;
      logic [drap_pkg::NAVG_W-1:0] near_average;
      logic [drap_pkg::FAVG_W-1:0] far_average;
      logic                        far_chosen;
   } position_result_type;

   typedef enum int {NEAR_WIN = 0, FAR_WIN = 1} window_id_type;

   // -------------------------------------------------------------------------
   // Scoreboard: keeps its own copy of the registers and of both windows,
   // turns every accepted reading into the expected response, and checks the
   // responses in arrival order.
   // -------------------------------------------------------------------------
   class position_scoreboard;
      drap_pkg::cfg_type   regs;
      logic [10:0]         win_store[2][drap_pkg::WINDOW];
      logic [15:0]         win_sum[2];
      logic [4:0]          win_count[2];
      logic [4:0]          win_slot[2];
      position_result_type pending_positions[$];
      int                  failures;
      int                  results_seen;

      function new();
         regs.shift_exponent    = drap_pkg::RST_SHIFT_EXPONENT;
         regs.near_offset       = drap_pkg::RST_NEAR_OFFSET;
         regs.far_offset        = drap_pkg::RST_FAR_OFFSET;
         regs.track_length      = drap_pkg::RST_TRACK_LENGTH;
         regs.fallback_distance = drap_pkg::RST_FALLBACK_DISTANCE;
         for (int w = 0; w < 2; w++) begin
            win_sum[w]   = '0;
            win_count[w] = '0;
            win_slot[w]  = '0;
         end
         failures     = 0;
         results_seen = 0;
      endfunction

      // Unknown indexes are dropped; only the low bits of the shift count.
      function void set_register(logic [drap_pkg::CSR_INDEX_W-1:0] index,
                                 logic [7:0] value);
         case (index)
            drap_pkg::CSR_SHIFT_EXPONENT:    regs.shift_exponent    = value[2:0];
            drap_pkg::CSR_NEAR_OFFSET:       regs.near_offset       = value;
            drap_pkg::CSR_FAR_OFFSET:        regs.far_offset        = value;
            drap_pkg::CSR_TRACK_LENGTH:      regs.track_length      = value;
            drap_pkg::CSR_FALLBACK_DISTANCE: regs.fallback_distance = value;
            default: ;
         endcase
      endfunction

      // Once a window is full the sample being overwritten leaves the sum.
      function void add_sample(window_id_type w, logic [10:0] value);
         logic [4:0] s;
         s = win_slot[w];
         if (s >= drap_pkg::WINDOW) s = '0;
         if (win_count[w] >= drap_pkg::WINDOW)
            win_sum[w] -= 16'(win_store[w][s]);
         else
            win_count[w]++;
         win_store[w][s] = value;
         win_sum[w] += 16'(value);
         s++;
         if (s >= drap_pkg::WINDOW) s = '0;
         win_slot[w] = s;
      endfunction

      function int unsigned window_average(window_id_type w);
         if (win_count[w] == 0) return 0;
         return (32'(win_sum[w]) * 256) / 32'(win_count[w]);
      endfunction

      function position_result_type predict_position(sensor_reading_type item);
         logic [8:0]          raw_cm;
         logic [7:0]          near_cm;
         logic [10:0]         far_cm;
         int unsigned         near_avg;
         int unsigned         far_avg;
         bit                  near_wins;
         position_result_type r;
         // Whole centimetres plus the sixteenths nibble, before the shift.
         raw_cm = 9'(item.near_high) + 9'(item.near_low[7:4]);
         if (item.near_ok)
            near_cm = 8'((raw_cm >> regs.shift_exponent) + 9'(regs.near_offset));
         else
            near_cm = regs.fallback_distance;
         add_sample(NEAR_WIN, 11'(near_cm));
         if (item.far_ready) begin
            far_cm = 11'(item.far_mm / 10) + 11'(regs.far_offset);
            add_sample(FAR_WIN, far_cm);
         end
         near_avg = window_average(NEAR_WIN);
         far_avg  = window_average(FAR_WIN);
         // Exact comparison of the two fractions; an empty far window never
         // loses to the near side.
         near_wins = (win_count[FAR_WIN] != 0) &&
                     (32'(win_sum[NEAR_WIN]) * 32'(win_count[FAR_WIN]) <
                      32'(win_sum[FAR_WIN]) * 32'(win_count[NEAR_WIN]));
         r.far_chosen   = !near_wins;
         r.position     = near_wins ? drap_pkg::POS_W'(near_avg)
                                    : drap_pkg::POS_W'(32'(regs.track_length) * 256
                                                       - far_avg);
         r.near_average = drap_pkg::NAVG_W'(near_avg);
         r.far_average  = drap_pkg::FAVG_W'(far_avg);
         return r;
      endfunction

      function void flag(string text);
         failures++;
         if (failures <= REPORT_LIMIT) $display("%s", text);
      endfunction

      function void note_reading(sensor_reading_type item);
         pending_positions.push_back(predict_position(item));
      endfunction

      function void check_result(position_result_type got);
         position_result_type want;
         results_seen++;
         if (pending_positions.size() == 0) begin
            flag($sformatf("unexpected response %0d: position %0d", results_seen,
                           $signed(got.position)));
            return;
         end
         want = pending_positions.pop_front();
         if (got.position != want.position || got.near_average != want.near_average ||
             got.far_average != want.far_average || got.far_chosen != want.far_chosen)
            flag($sformatf({"mismatch on response %0d: position %0d/%0d, ",
                            "near_average %0d/%0d, far_average %0d/%0d, ",
                            "far_chosen %0d/%0d (expected/actual)"},
                           results_seen, $signed(want.position), $signed(got.position),
                           want.near_average, got.near_average,
                           want.far_average, got.far_average,
                           want.far_chosen, got.far_chosen));
      endfunction

      function int pending();
         return pending_positions.size();
      endfunction

      function int close_out();
         if (pending_positions.size() != 0)
            flag($sformatf("%0d responses never arrived", pending_positions.size()));
         return failures;
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and the unit itself.
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                             csr_we;
   logic [drap_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [drap_pkg::CSR_DATA_W-1:0]  csr_wdata;

   drap_req_if req_bus ();
   drap_rsp_if rsp_bus ();

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   dual_range_average_position_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   position_scoreboard board = new();

   // When set, the request side sends back to back for a stretch of items.
   bit sender_steady = 1'b0;

   // -------------------------------------------------------------------------
   // Request side. Every task is entered right after a rising edge and leaves
   // right after one. Valid stays high from one transaction to the next when
   // there is no gap, so it is never lowered and raised in the same step.
   // -------------------------------------------------------------------------
   task automatic send_reading(input sensor_reading_type item);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.near_high <= item.near_high;
      req_bus.near_low  <= item.near_low;
      req_bus.near_ok   <= item.near_ok;
      req_bus.far_mm    <= item.far_mm;
      req_bus.far_ready <= item.far_ready;
      // The values read here are the ones the unit saw at this edge.
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      board.note_reading(item);
   endtask

   function automatic sensor_reading_type reading(logic [7:0] high, logic [7:0] low,
                                                  logic ok,
                                                  logic [drap_pkg::FAR_MM_W-1:0] mm,
                                                  logic rdy);
      sensor_reading_type r;
      r.near_high = high;
      r.near_low  = low;
      r.near_ok   = ok;
      r.far_mm    = mm;
      r.far_ready = rdy;
      return r;
   endfunction

   // Mostly good near reads; far ranges either anywhere in the 13-bit span or
   // short enough that the two averages land close to each other, so both
   // sides of the position choice are exercised.
   function automatic sensor_reading_type random_reading();
      logic [drap_pkg::FAR_MM_W-1:0] mm;
      case ($urandom_range(0, 3))
         0:       mm = drap_pkg::FAR_MM_W'($urandom_range(0, 8191));
         1:       mm = drap_pkg::FAR_MM_W'($urandom_range(0, 3000));
         default: mm = drap_pkg::FAR_MM_W'($urandom_range(0, 1500));
      endcase
      return reading(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     $urandom_range(0, 9) != 0, mm, $urandom_range(0, 3) != 0);
   endfunction

   // Writes all five registers, then every spare index. The shift register
   // gets random garbage in the bits above its three. The write enable stays
   // high across the burst and drops once at the end.
   task automatic program_registers(input drap_pkg::cfg_type next);
      logic [drap_pkg::CSR_INDEX_W-1:0] idx [drap_pkg::CSR_FALLBACK_DISTANCE + 1];
      logic [7:0]                       val [drap_pkg::CSR_FALLBACK_DISTANCE + 1];
      idx[0] = drap_pkg::CSR_SHIFT_EXPONENT;
      val[0] = {5'($urandom_range(0, 31)), next.shift_exponent};
      idx[1] = drap_pkg::CSR_NEAR_OFFSET;       val[1] = next.near_offset;
      idx[2] = drap_pkg::CSR_FAR_OFFSET;        val[2] = next.far_offset;
      idx[3] = drap_pkg::CSR_TRACK_LENGTH;      val[3] = next.track_length;
      idx[4] = drap_pkg::CSR_FALLBACK_DISTANCE; val[4] = next.fallback_distance;
      for (int i = 0; i <= int'(drap_pkg::CSR_FALLBACK_DISTANCE); i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         board.set_register(idx[i], val[i]);
      end
      for (int i = FIRST_SPARE_INDEX; i < (1 << drap_pkg::CSR_INDEX_W); i++) begin
         csr_we    <= 1'b1;
         csr_index <= drap_pkg::CSR_INDEX_W'(i);
         csr_wdata <= 8'($urandom_range(0, 255));
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Waits for every expected response, then lets the back end go quiet.
   task automatic settle_unit();
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Directed transactions at the reset register values.
   task automatic run_directed_readings();
      // The first reading leaves the far window empty, so the mirrored
      // track length wins with a zero far average.
      send_reading(reading(8'd0,   8'h00, 1'b1, 13'd0,    1'b0));
      // Largest raw near value: the near sample wraps past 255.
      send_reading(reading(8'd255, 8'hFF, 1'b1, 13'd8191, 1'b0));
      // Failed near read takes the fallback; largest far range.
      send_reading(reading(8'd255, 8'hF0, 1'b0, 13'd8191, 1'b1));
      // Low nibble of the second byte carries nothing; zero far range.
      send_reading(reading(8'd128, 8'h0F, 1'b1, 13'd0,    1'b1));
      // Far ranges just under and at one centimetre.
      send_reading(reading(8'd10,  8'h80, 1'b1, 13'd9,    1'b1));
      send_reading(reading(8'd20,  8'h10, 1'b1, 13'd10,   1'b1));
      send_reading(reading(8'd0,   8'h00, 1'b0, 13'd4000, 1'b1));
      // Close near readings against far ones: the near average takes over.
      for (int i = 0; i < 10; i++)
         send_reading(reading(8'(i * 3), 8'(i * 17), 1'b1, 13'd8000, 1'b1));
      // Zero far ranges pull the far average down, but it stays above the near one.
      for (int i = 0; i < 5; i++)
         send_reading(reading(8'd200, 8'hA5, 1'b1, 13'd0, 1'b1));
      req_bus.valid <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Response side: random stall before each transaction, stretches with no
   // stall, and two long hold-offs while the request side keeps offering.
   // -------------------------------------------------------------------------
   initial begin : response_sink
      int stall;
      int taken;
      bit steady;
      position_result_type got;
      rsp_bus.ready <= 1'b0;
      taken  = 0;
      steady = 1'b0;
      @(negedge reset);
      forever begin
         if (taken % 64 == 0) steady = ($urandom_range(0, 3) == 0);
         stall = steady ? 0 : $urandom_range(0, 16);
         if (taken == 150 || taken == 1000) stall = LONG_HOLD_CYCLES;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         got.position     = rsp_bus.position;
         got.near_average = rsp_bus.near_average;
         got.far_average  = rsp_bus.far_average;
         got.far_chosen   = rsp_bus.far_chosen;
         board.check_result(got);
         taken++;
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence: reset, directed transactions, then random phases, each
   // under a new register setting written while the unit is idle. The first
   // two phases use all-low and all-high register values.
   // -------------------------------------------------------------------------
   initial begin : main_sequence
      drap_pkg::cfg_type next;
      int                failures;
      req_bus.valid     <= 1'b0;
      req_bus.near_high <= '0;
      req_bus.near_low  <= '0;
      req_bus.near_ok   <= 1'b0;
      req_bus.far_mm    <= '0;
      req_bus.far_ready <= 1'b0;
      csr_we            <= 1'b0;
      csr_index         <= '0;
      csr_wdata         <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      run_directed_readings();
      settle_unit();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: next = '0;
            1: next = '1;
            default: begin
               next.shift_exponent    = 3'($urandom_range(0, 7));
               next.near_offset       = 8'($urandom_range(0, 255));
               next.far_offset        = 8'($urandom_range(0, 255));
               next.track_length      = 8'($urandom_range(0, 255));
               next.fallback_distance = 8'($urandom_range(0, 255));
            end
         endcase
         program_registers(next);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Every 40 transactions, sometimes switch to back-to-back sending.
            if (n % 40 == 0) sender_steady = ($urandom_range(0, 3) == 0);
            send_reading(random_reading());
         end
         req_bus.valid <= 1'b0;
         settle_unit();
      end

      failures = board.close_out();
      if (failures == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Safety net: several times the slowest legal run.
   initial begin : watchdog
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule
